@@ hdl/css_pkg.sv @@
// Shared types and constants of the chroma spill suppressor.
// No dependencies; every other file of the block refers to it by scoped names.
package css_pkg;

  localparam int unsigned DATA_W     = 16;  // signed Q4.12 pixel component
  localparam int unsigned FRAC_W     = 12;  // fraction bits of Q4.12 and of the amount
  localparam int unsigned AMT_W      = 15;  // unsigned Q3.12 suppression amount
  localparam int unsigned MASK_W     = 6;
  localparam int unsigned DIFF_W     = DATA_W + 2;  // holds a + b - 2k
  localparam int unsigned PROD_W     = DIFF_W + AMT_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_METHOD = 2'd0,
    REG_KEY    = 2'd1,
    REG_AMOUNT = 2'd2,
    REG_MASK   = 2'd3
  } reg_idx_e;

  // method_select codes
  localparam logic METHOD_BASIC    = 1'b0;
  localparam logic METHOD_DISCREET = 1'b1;

  // key_color codes
  localparam logic KEY_BLUE  = 1'b0;
  localparam logic KEY_GREEN = 1'b1;

  // operation_mask bit positions
  localparam int unsigned MASK_RED     = 0;
  localparam int unsigned MASK_GREEN   = 1;
  localparam int unsigned MASK_BLUE    = 2;
  localparam int unsigned MASK_CYAN    = 3;
  localparam int unsigned MASK_MAGENTA = 4;
  localparam int unsigned MASK_YELLOW  = 5;

  // Reset values of the registers
  localparam logic              METHOD_RST = METHOD_BASIC;
  localparam logic              KEY_RST    = KEY_BLUE;
  localparam logic [AMT_W-1:0]  AMOUNT_RST = 15'd4096;
  localparam logic [MASK_W-1:0] MASK_RST   = 6'd4;

  typedef struct packed {
    logic signed [DATA_W-1:0] red;
    logic signed [DATA_W-1:0] green;
    logic signed [DATA_W-1:0] blue;
    logic signed [DATA_W-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic              method;
    logic              key_color;
    logic [AMT_W-1:0]  amount;
    logic [MASK_W-1:0] mask;
  } cfg_t;

  // Beat from the shaping stages to the blend stages: per-channel offsets
  // that get scaled by the amount, plus the original pixel.
  typedef struct packed {
    logic                     disc;
    logic signed [DIFF_W-1:0] diff_r;
    logic signed [DIFF_W-1:0] diff_g;
    logic signed [DIFF_W-1:0] diff_b;
    pixel_t                   orig;
  } shape_t;

endpackage

@@ hdl/css_if.sv @@
// Channel interfaces of the chroma spill suppressor: pixel in, pixel out, config write.
// Depends on css_pkg for widths.
interface css_pix_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [css_pkg::DATA_W-1:0] red_in;
  logic signed [css_pkg::DATA_W-1:0] green_in;
  logic signed [css_pkg::DATA_W-1:0] blue_in;
  logic signed [css_pkg::DATA_W-1:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                input alpha_in, output ready);
endinterface

interface css_pix_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [css_pkg::DATA_W-1:0] red_out;
  logic signed [css_pkg::DATA_W-1:0] green_out;
  logic signed [css_pkg::DATA_W-1:0] blue_out;
  logic signed [css_pkg::DATA_W-1:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input alpha_out, output ready);
endinterface

interface css_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [css_pkg::CFG_IDX_W-1:0]      index;
  logic [css_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/css_cfg_regs.sv @@
// Configuration register file of the chroma spill suppressor.
// Depends on css_pkg.
module css_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [css_pkg::CFG_IDX_W-1:0]  index_i,
  input  logic [css_pkg::CFG_DATA_W-1:0] data_i,
  output css_pkg::cfg_t                  cfg_o
);

  css_pkg::cfg_t cfg_q, cfg_d;

  assign ready_o = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (valid_i) begin
      unique case (css_pkg::reg_idx_e'(index_i))
        css_pkg::REG_METHOD: cfg_d.method    = data_i[0];
        css_pkg::REG_KEY:    cfg_d.key_color = data_i[0];
        css_pkg::REG_AMOUNT: cfg_d.amount    = data_i[css_pkg::AMT_W-1:0];
        css_pkg::REG_MASK:   cfg_d.mask      = data_i[css_pkg::MASK_W-1:0];
        default:             cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.method    <= css_pkg::METHOD_RST;
      cfg_q.key_color <= css_pkg::KEY_RST;
      cfg_q.amount    <= css_pkg::AMOUNT_RST;
      cfg_q.mask      <= css_pkg::MASK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ hdl/css_shape.sv @@
// Shaping stages 1 and 2: channel clamps, pair lowering and basic key detection.
// Depends on css_pkg.
module css_shape (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  css_pkg::cfg_t   cfg_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  css_pkg::pixel_t pix_i,
  output logic            valid_o,
  input  logic            ready_i,
  output css_pkg::shape_t shape_o
);

  localparam int unsigned DW = css_pkg::DATA_W;
  localparam int unsigned XW = css_pkg::DATA_W + 1;

  typedef struct packed {
    logic                              disc;
    logic                              key_green;
    logic                              target;
    logic signed [css_pkg::DIFF_W-1:0] bdiff;
    logic signed [DW-1:0]              r;
    logic signed [DW-1:0]              g;
    logic signed [DW-1:0]              b;
    css_pkg::pixel_t                   orig;
  } clamp_t;

  logic            v1_q, v2_q;
  logic            adv1, adv2;
  clamp_t          s1_q, s1_d;
  css_pkg::shape_t s2_q, s2_d;

  logic signed [DW-1:0] c_r, c_g, c_b, c_m;
  logic signed [DW-1:0] k_key, k_a, k_o;
  logic signed [DW-1:0] l_r, l_g, l_b, l_m;
  logic signed [XW-1:0] l_e;

  assign adv2    = !v2_q || ready_i;
  assign adv1    = !v1_q || adv2;
  assign ready_o = adv1;
  assign valid_o = v2_q;
  assign shape_o = s2_q;

  // Stage 1: clamp steps in order, and the basic-mode key test
  always_comb begin
    c_r = pix_i.red;
    c_g = pix_i.green;
    c_b = pix_i.blue;
    c_m = '0;
    if (cfg_i.mask[css_pkg::MASK_RED]) begin
      c_m = (c_g > c_b) ? c_g : c_b;
      if (c_r > c_m) c_r = c_m;
    end
    if (cfg_i.mask[css_pkg::MASK_GREEN]) begin
      c_m = (c_r > c_b) ? c_r : c_b;
      if (c_g > c_m) c_g = c_m;
    end
    if (cfg_i.mask[css_pkg::MASK_BLUE]) begin
      c_m = (c_r > c_g) ? c_r : c_g;
      if (c_b > c_m) c_b = c_m;
    end

    if (cfg_i.key_color == css_pkg::KEY_GREEN) begin
      k_key = pix_i.green;
      k_o   = pix_i.blue;
    end else begin
      k_key = pix_i.blue;
      k_o   = pix_i.green;
    end
    k_a = pix_i.red;

    s1_d.disc      = (cfg_i.method == css_pkg::METHOD_DISCREET);
    s1_d.key_green = (cfg_i.key_color == css_pkg::KEY_GREEN);
    s1_d.target    = (k_key > k_a) && (k_key > k_o);
    s1_d.bdiff     = css_pkg::DIFF_W'(k_a) + css_pkg::DIFF_W'(k_o)
                   - (css_pkg::DIFF_W'(k_key) <<< 1);
    s1_d.r         = c_r;
    s1_d.g         = c_g;
    s1_d.b         = c_b;
    s1_d.orig      = pix_i;
  end

  // Stage 2: pair lowering steps, then offsets against the original
  always_comb begin
    l_r = s1_q.r;
    l_g = s1_q.g;
    l_b = s1_q.b;
    l_m = '0;
    l_e = '0;
    if (cfg_i.mask[css_pkg::MASK_CYAN]) begin
      l_m = (l_g < l_b) ? l_g : l_b;
      if (l_m > l_r) begin
        l_e = XW'(l_m) - XW'(l_r);
        l_g = DW'(XW'(l_g) - l_e);
        l_b = DW'(XW'(l_b) - l_e);
      end
    end
    if (cfg_i.mask[css_pkg::MASK_MAGENTA]) begin
      l_m = (l_r < l_b) ? l_r : l_b;
      if (l_m > l_g) begin
        l_e = XW'(l_m) - XW'(l_g);
        l_r = DW'(XW'(l_r) - l_e);
        l_b = DW'(XW'(l_b) - l_e);
      end
    end
    if (cfg_i.mask[css_pkg::MASK_YELLOW]) begin
      l_m = (l_r < l_g) ? l_r : l_g;
      if (l_m > l_b) begin
        l_e = XW'(l_m) - XW'(l_b);
        l_r = DW'(XW'(l_r) - l_e);
        l_g = DW'(XW'(l_g) - l_e);
      end
    end

    s2_d.disc = s1_q.disc;
    s2_d.orig = s1_q.orig;
    if (s1_q.disc) begin
      s2_d.diff_r = css_pkg::DIFF_W'(l_r) - css_pkg::DIFF_W'(s1_q.orig.red);
      s2_d.diff_g = css_pkg::DIFF_W'(l_g) - css_pkg::DIFF_W'(s1_q.orig.green);
      s2_d.diff_b = css_pkg::DIFF_W'(l_b) - css_pkg::DIFF_W'(s1_q.orig.blue);
    end else begin
      s2_d.diff_r = '0;
      s2_d.diff_g = (s1_q.target && s1_q.key_green) ? s1_q.bdiff : '0;
      s2_d.diff_b = (s1_q.target && !s1_q.key_green) ? s1_q.bdiff : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) s1_q <= s1_d;
    if (adv2 && v1_q)    s2_q <= s2_d;
  end

`ifndef ASSERT_OFF
  a_disc_only_lowers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && s2_q.disc |-> s2_q.diff_r <= 0 && s2_q.diff_g <= 0 && s2_q.diff_b <= 0)
    else $error("discreet step raised a channel");
  a_basic_one_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !s2_q.disc |-> s2_q.diff_r == 0 && (s2_q.diff_g == 0 || s2_q.diff_b == 0))
    else $error("basic mode moved more than the key channel");
`endif

endmodule

@@ hdl/css_blend.sv @@
// Blend stages 3 and 4: scale offsets by the amount, round, add back and saturate.
// Depends on css_pkg.
module css_blend (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  css_pkg::cfg_t   cfg_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  css_pkg::shape_t shape_i,
  output logic            valid_o,
  input  logic            ready_i,
  output css_pkg::pixel_t pix_o
);

  localparam int unsigned DW     = css_pkg::DATA_W;
  localparam int unsigned PW     = css_pkg::PROD_W;
  localparam int unsigned RW     = PW + 1;
  localparam int unsigned SW     = PW - css_pkg::FRAC_W;  // rounded step width
  localparam int unsigned TW     = SW + 1;                // sum width
  localparam int unsigned SH_D   = css_pkg::FRAC_W;
  localparam int unsigned SH_B   = css_pkg::FRAC_W + 1;
  localparam logic signed [RW-1:0] HALF_D = RW'(1) <<< (SH_D - 1);
  localparam logic signed [RW-1:0] HALF_B = RW'(1) <<< (SH_B - 1);
  localparam logic signed [TW-1:0] SAT_HI = TW'((2 ** (DW - 1)) - 1);
  localparam logic signed [TW-1:0] SAT_LO = -TW'(2 ** (DW - 1));

  typedef struct packed {
    logic                 disc;
    logic signed [PW-1:0] prod_r;
    logic signed [PW-1:0] prod_g;
    logic signed [PW-1:0] prod_b;
    css_pkg::pixel_t      orig;
  } prod_t;

  logic            v3_q, v4_q;
  logic            adv3, adv4;
  prod_t           s3_q, s3_d;
  css_pkg::pixel_t s4_q, s4_d;
  logic signed [css_pkg::AMT_W:0] amt_s;

  // Round to nearest with ties upward, add to the original, saturate
  function automatic logic signed [DW-1:0] finish(input logic signed [PW-1:0] p,
                                                  input logic signed [DW-1:0] orig,
                                                  input logic disc);
    logic signed [RW-1:0] rnd;
    logic signed [TW-1:0] sum;
    rnd = disc ? ((RW'(p) + HALF_D) >>> SH_D) : ((RW'(p) + HALF_B) >>> SH_B);
    sum = TW'(orig) + TW'($signed(rnd[SW-1:0]));
    if (sum > SAT_HI) begin
      finish = SAT_HI[DW-1:0];
    end else if (sum < SAT_LO) begin
      finish = SAT_LO[DW-1:0];
    end else begin
      finish = sum[DW-1:0];
    end
  endfunction

  assign adv4    = !v4_q || ready_i;
  assign adv3    = !v3_q || adv4;
  assign ready_o = adv3;
  assign valid_o = v4_q;
  assign pix_o   = s4_q;
  assign amt_s   = {1'b0, cfg_i.amount};

  // Stage 3: one multiplier per channel
  always_comb begin
    s3_d.disc   = shape_i.disc;
    s3_d.orig   = shape_i.orig;
    s3_d.prod_r = shape_i.diff_r * amt_s;
    s3_d.prod_g = shape_i.diff_g * amt_s;
    s3_d.prod_b = shape_i.diff_b * amt_s;
  end

  // Stage 4: round, add back to the original and saturate
  always_comb begin
    s4_d.red   = finish(s3_q.prod_r, s3_q.orig.red, s3_q.disc);
    s4_d.green = finish(s3_q.prod_g, s3_q.orig.green, s3_q.disc);
    s4_d.blue  = finish(s3_q.prod_b, s3_q.orig.blue, s3_q.disc);
    s4_d.alpha = s3_q.orig.alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv3) v3_q <= valid_i;
      if (adv4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && valid_i) s3_q <= s3_d;
    if (adv4 && v3_q)    s4_q <= s4_d;
  end

`ifndef ASSERT_OFF
  a_basic_red_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !s3_q.disc |-> s3_q.prod_r == 0)
    else $error("basic mode scaled the red channel");
  a_disc_prod_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && s3_q.disc |-> s3_q.prod_r <= 0 && s3_q.prod_g <= 0 && s3_q.prod_b <= 0)
    else $error("discreet blend product is positive");
`endif

endmodule

@@ hdl/chroma_spill_suppressor.sv @@
// Chroma spill suppressor, top level. Throughput: one pixel per clock while the output
// is ready; four register stages (clamp, pair lowering, multiply, round/saturate),
// each with its own valid bit, so a stalled output only holds stages that are
// occupied. Reset: all valid bits clear, registers return to basic mode, blue key,
// amount 1.0, mask blue; there is no clearing pass.
module chroma_spill_suppressor (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  css_cfg_if.sink              cfg_i,
  css_pix_in_if.sink           pix_i,
  css_pix_out_if.source        pix_o
);

  css_pkg::cfg_t   cfg;
  css_pkg::pixel_t in_pix;
  css_pkg::pixel_t out_pix;
  css_pkg::shape_t shape;
  logic            shape_valid;
  logic            shape_ready;

  // Configuration writes are registered; the port never stalls.
  css_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cfg_i.valid),
    .ready_o (cfg_i.ready),
    .index_i (cfg_i.index),
    .data_i  (cfg_i.data),
    .cfg_o   (cfg)
  );

  // Pack the input beat into the internal pixel type
  assign in_pix.red   = pix_i.red_in;
  assign in_pix.green = pix_i.green_in;
  assign in_pix.blue  = pix_i.blue_in;
  assign in_pix.alpha = pix_i.alpha_in;

  // Stages 1-2: basic mode picks the key channel and forms (a + b - 2k);
  // discreet mode runs the six masked steps and forms (v - orig).
  css_shape u_shape (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (pix_i.valid),
    .ready_o (pix_i.ready),
    .pix_i   (in_pix),
    .valid_o (shape_valid),
    .ready_i (shape_ready),
    .shape_o (shape)
  );

  // Stages 3-4: scale by the amount (2^-13 for basic, 2^-12 for discreet),
  // round half up, add back to the original and saturate. The last stage
  // register is the output register.
  css_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (shape_valid),
    .ready_o (shape_ready),
    .shape_i (shape),
    .valid_o (pix_o.valid),
    .ready_i (pix_o.ready),
    .pix_o   (out_pix)
  );

  // Unpack the result beat onto the output channel
  assign pix_o.red_out   = out_pix.red;
  assign pix_o.green_out = out_pix.green;
  assign pix_o.blue_out  = out_pix.blue;
  assign pix_o.alpha_out = out_pix.alpha;

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench of chroma_spill_suppressor: random and corner-case pixels
// under several register settings, checked beat by beat against a built-in predictor.
// Depends on hdl/css_pkg.sv, hdl/css_if.sv and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIPE_LATENCY = 4;
  localparam int unsigned SETTLE       = PIPE_LATENCY + 2;
  localparam int unsigned STALL_LIMIT  = 4000;  // cycles without any beat
  localparam int unsigned HOLD_CYCLES  = 400;   // long output back-pressure stretch

  // Receiver back-pressure styles
  typedef enum int unsigned {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_RARELY,
    RX_PERIODIC
  } rx_style_e;

  // Flavors of random pixels
  typedef enum int unsigned {
    PX_ANY,
    PX_SCREEN,
    PX_TIE,
    PX_EXTREME,
    PX_CLOSE,
    PX_KEYED
  } px_kind_e;

  // Holds the register copy and the suppressed pixels still owed by the block.
  class spill_checker;
    css_pkg::cfg_t   regs;
    css_pkg::pixel_t owed_px[$];
    int unsigned     errors;

    function new();
      regs.method    = css_pkg::METHOD_RST;
      regs.key_color = css_pkg::KEY_RST;
      regs.amount    = css_pkg::AMOUNT_RST;
      regs.mask      = css_pkg::MASK_RST;
      errors         = 0;
    endfunction

    function void write_reg(css_pkg::reg_idx_e idx, logic [css_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        css_pkg::REG_METHOD: regs.method    = data[0];
        css_pkg::REG_KEY:    regs.key_color = data[0];
        css_pkg::REG_AMOUNT: regs.amount    = data[css_pkg::AMT_W-1:0];
        css_pkg::REG_MASK:   regs.mask      = data[css_pkg::MASK_W-1:0];
        default: ;
      endcase
    endfunction

    // Nearest step, ties toward plus infinity: floor((x + half) / 2^s).
    function longint round_half_up(longint x, int unsigned s);
      return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function logic signed [css_pkg::DATA_W-1:0] clip_q12(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[css_pkg::DATA_W-1:0];
    endfunction

    // k + ((a + b)/2 - k) * amount, product carried in 2^-25 units
    function longint pull_toward_mean(int k, int a, int b);
      longint amt, d2;
      amt = longint'(regs.amount);
      d2  = longint'(a) + b - 2 * longint'(k);
      return k + round_half_up(d2 * amt, css_pkg::FRAC_W + 1);
    endfunction

    function longint mix_with_orig(int v, int orig);
      longint amt, d;
      amt = longint'(regs.amount);
      d   = longint'(v) - orig;
      return orig + round_half_up(d * amt, css_pkg::FRAC_W);
    endfunction

    function css_pkg::pixel_t suppress_pixel(css_pkg::pixel_t px);
      int              r0, g0, b0, r, g, b, m;
      longint          ro, go, bo;
      css_pkg::pixel_t res;
      r0 = int'(px.red);
      g0 = int'(px.green);
      b0 = int'(px.blue);
      ro = longint'(r0);
      go = longint'(g0);
      bo = longint'(b0);
      if (regs.method == css_pkg::METHOD_BASIC) begin
        if (regs.key_color == css_pkg::KEY_BLUE) begin
          if (b0 > r0 && b0 > g0) bo = pull_toward_mean(b0, r0, g0);
        end else begin
          if (g0 > r0 && g0 > b0) go = pull_toward_mean(g0, r0, b0);
        end
      end else begin
        r = r0;
        g = g0;
        b = b0;
        if (regs.mask[css_pkg::MASK_RED]) begin
          m = (g > b) ? g : b;
          if (r > m) r = m;
        end
        if (regs.mask[css_pkg::MASK_GREEN]) begin
          m = (r > b) ? r : b;
          if (g > m) g = m;
        end
        if (regs.mask[css_pkg::MASK_BLUE]) begin
          m = (r > g) ? r : g;
          if (b > m) b = m;
        end
        if (regs.mask[css_pkg::MASK_CYAN]) begin
          m = (g < b) ? g : b;
          if (m > r) begin
            g -= m - r;
            b -= m - r;
          end
        end
        if (regs.mask[css_pkg::MASK_MAGENTA]) begin
          m = (r < b) ? r : b;
          if (m > g) begin
            r -= m - g;
            b -= m - g;
          end
        end
        if (regs.mask[css_pkg::MASK_YELLOW]) begin
          m = (r < g) ? r : g;
          if (m > b) begin
            r -= m - b;
            g -= m - b;
          end
        end
        ro = mix_with_orig(r, r0);
        go = mix_with_orig(g, g0);
        bo = mix_with_orig(b, b0);
      end
      res.red   = clip_q12(ro);
      res.green = clip_q12(go);
      res.blue  = clip_q12(bo);
      res.alpha = px.alpha;
      return res;
    endfunction

    function void note_pixel(css_pkg::pixel_t px);
      owed_px.push_back(suppress_pixel(px));
    endfunction

    function int unsigned pending();
      return owed_px.size();
    endfunction

    function void compare_field(string field, logic signed [css_pkg::DATA_W-1:0] want,
                                logic signed [css_pkg::DATA_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_pixel(css_pkg::pixel_t got);
      css_pkg::pixel_t want;
      if (owed_px.size() == 0) begin
        errors++;
        $display("%0t: output beat with nothing owed, got r=%0d g=%0d b=%0d a=%0d",
                 $time, got.red, got.green, got.blue, got.alpha);
        return;
      end
      want = owed_px.pop_front();
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha", want.alpha, got.alpha);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  css_cfg_if     cfg_bus ();
  css_pix_in_if  pix_in ();
  css_pix_out_if pix_out ();

  spill_checker sb = new();

  int unsigned hold_request = 0;  // set by the stimulus, consumed by the receiver
  int unsigned quiet_cycles = 0;

  chroma_spill_suppressor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .pix_i  (pix_in),
    .pix_o  (pix_out)
  );

  always #4 clk_i = ~clk_i;

  // Watch every channel at the edge: register writes update the copy of the
  // registers, input beats queue a prediction, output beats get checked.
  always @(posedge clk_i) begin
    if (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)
      sb.write_reg(css_pkg::reg_idx_e'(cfg_bus.index), cfg_bus.data);
    if (pix_in.valid === 1'b1 && pix_in.ready === 1'b1)
      sb.note_pixel(css_pkg::pixel_t'{pix_in.red_in, pix_in.green_in, pix_in.blue_in,
                                      pix_in.alpha_in});
    if (pix_out.valid === 1'b1 && pix_out.ready === 1'b1)
      sb.check_pixel(css_pkg::pixel_t'{pix_out.red_out, pix_out.green_out,
                                       pix_out.blue_out, pix_out.alpha_out});
  end

  // Count cycles in which no beat moves on any channel.
  always @(posedge clk_i) begin
    if ((pix_in.valid === 1'b1 && pix_in.ready === 1'b1) ||
        (pix_out.valid === 1'b1 && pix_out.ready === 1'b1) ||
        (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t: no beat for %0d cycles, %0d pixels still owed", $time, STALL_LIMIT,
             sb.pending());
    $display("[chroma_spill_suppressor] ERROR");
    $finish;
  end

  // Output side: pick a new random back-pressure style whenever the current one runs out,
  // and honor a hold-off request by dropping ready for the requested count.
  initial begin : receiver
    rx_style_e   style;
    int unsigned style_left, period, tick, hold_left;
    pix_out.ready = 1'b0;
    style      = RX_ALWAYS;
    style_left = 0;
    period     = 2;
    tick       = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (style_left == 0) begin
        style      = rx_style_e'($urandom_range(0, 3));
        style_left = $urandom_range(16, 96);
        period     = $urandom_range(2, 7);
      end
      style_left--;
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        pix_out.ready <= 1'b0;
      end else begin
        case (style)
          RX_ALWAYS:   pix_out.ready <= 1'b1;
          RX_MOSTLY:   pix_out.ready <= ($urandom_range(0, 3) != 0);
          RX_RARELY:   pix_out.ready <= ($urandom_range(0, 3) == 0);
          default:     pix_out.ready <= ((tick % period) == 0);
        endcase
      end
    end
  end

  // Offer one pixel and hold it until the block takes it. Valid stays high on
  // return; the caller drops it when a gap follows.
  task automatic send_pixel(input css_pkg::pixel_t px);
    pix_in.valid    <= 1'b1;
    pix_in.red_in   <= px.red;
    pix_in.green_in <= px.green;
    pix_in.blue_in  <= px.blue;
    pix_in.alpha_in <= px.alpha;
    do @(posedge clk_i); while (pix_in.ready !== 1'b1);
  endtask

  // Hold the input idle until every owed pixel is out, then let the pipe settle.
  task automatic wait_drain();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input css_pkg::reg_idx_e idx,
                           input logic [css_pkg::CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
  endtask

  // Write all four registers back to back; valid stays high between beats.
  task automatic apply_settings(input logic [css_pkg::CFG_DATA_W-1:0] method_d, key_d,
                                amount_d, mask_d);
    write_reg(css_pkg::REG_METHOD, method_d);
    write_reg(css_pkg::REG_KEY, key_d);
    write_reg(css_pkg::REG_AMOUNT, amount_d);
    write_reg(css_pkg::REG_MASK, mask_d);
    cfg_bus.valid <= 1'b0;
  endtask

  // Fill the bits above a register's width with noise; the block must drop them.
  function automatic logic [css_pkg::CFG_DATA_W-1:0] with_junk(
      input logic [css_pkg::CFG_DATA_W-1:0] value, input int unsigned width);
    logic [css_pkg::CFG_DATA_W-1:0] keep, junk;
    keep = css_pkg::CFG_DATA_W'((32'h1 << width) - 32'h1);
    junk = css_pkg::CFG_DATA_W'($urandom());
    return (junk & ~keep) | (value & keep);
  endfunction

  function automatic logic [css_pkg::DATA_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0001;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic css_pkg::pixel_t random_pixel();
    css_pkg::pixel_t px;
    px_kind_e        kind;
    int              base;
    px   = {$urandom(), $urandom()};
    kind = ($urandom_range(0, 2) == 0) ? PX_ANY : px_kind_e'($urandom_range(0, 5));
    case (kind)
      PX_SCREEN: begin
        // ordinary footage: channels between 0 and a bit over 1.0
        px.red   = css_pkg::DATA_W'($urandom_range(0, 5000));
        px.green = css_pkg::DATA_W'($urandom_range(0, 5000));
        px.blue  = css_pkg::DATA_W'($urandom_range(0, 5000));
      end
      PX_TIE: begin
        case ($urandom_range(0, 2))
          0:       px.blue  = px.red;
          1:       px.green = px.blue;
          default: px.red   = px.green;
        endcase
      end
      PX_EXTREME: begin
        px.red   = pick_extreme();
        px.green = pick_extreme();
        px.blue  = pick_extreme();
      end
      PX_CLOSE: begin
        base     = int'($urandom_range(0, 65535));
        base     = base - 32768;
        px.red   = css_pkg::DATA_W'(base + int'($urandom_range(0, 6)) - 3);
        px.green = css_pkg::DATA_W'(base + int'($urandom_range(0, 6)) - 3);
        px.blue  = css_pkg::DATA_W'(base + int'($urandom_range(0, 6)) - 3);
      end
      PX_KEYED: begin
        // strong key in blue or green, the rest low
        px.red = css_pkg::DATA_W'($urandom_range(0, 4096));
        if ($urandom_range(0, 1) != 0) begin
          px.blue  = css_pkg::DATA_W'($urandom_range(20000, 32767));
          px.green = css_pkg::DATA_W'($urandom_range(0, 4096));
        end else begin
          px.green = css_pkg::DATA_W'($urandom_range(20000, 32767));
          px.blue  = css_pkg::DATA_W'($urandom_range(0, 4096));
        end
      end
      default: ;
    endcase
    return px;
  endfunction

  // Stream random pixels in bursts with random gaps. A steady stream never
  // drops valid; pause_mid drains the block halfway through.
  task automatic send_stream(input int unsigned count, input bit steady, input bit pause_mid);
    int unsigned burst_left, gap;
    burst_left = $urandom_range(1, 40);
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(random_pixel());
      if (pause_mid && i == count / 2) begin
        pix_in.valid <= 1'b0;
        wait_drain();
      end else if (!steady) begin
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap        = $urandom_range(0, 8);
          if (gap != 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
      end
    end
  endtask

  initial begin : stimulus
    css_pkg::pixel_t                corner_px[12];
    logic                           method_v, key_v;
    logic [css_pkg::AMT_W-1:0]      amount_v;
    logic [css_pkg::MASK_W-1:0]     mask_v;
    int unsigned                    count;

    pix_in.valid    = 1'b0;
    pix_in.red_in   = '0;
    pix_in.green_in = '0;
    pix_in.blue_in  = '0;
    pix_in.alpha_in = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = css_pkg::REG_METHOD;
    cfg_bus.data    = '0;

    // Corner pixels: rails, ties between key and another channel, bit patterns,
    // a rounding tie and a key that just barely wins.
    corner_px = '{
      '{16'sd0,      16'sd0,      16'sd32767,  16'sh8000},
      '{16'sh8000,   16'sh8000,   16'sd32767,  16'sd32767},
      '{16'sd1000,   16'sd0,      16'sd1000,   16'sd1},
      '{16'sd0,      16'sd1000,   16'sd1000,   16'sd2},
      '{16'sh8000,   16'sh8000,   16'sh8000,   -16'sd1},
      '{16'sd32767,  16'sd32767,  16'sd32767,  16'sd0},
      '{16'sd100,    16'sd5000,   16'sd200,    16'sd4096},
      '{-16'sd1,     -16'sd2,     16'sd0,      -16'sd4096},
      '{16'sh5555,   16'shAAAA,   16'sh2AAA,   16'shD555},
      '{16'sd32767,  16'sh8000,   16'sd0,      16'sd12345},
      '{16'sd1,      16'sd0,      16'sd2,      16'sd0},
      '{-16'sd20000, 16'sd30000,  -16'sd20000, 16'sd7}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner pixels under the reset settings: basic, blue key, amount 1.0
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    pix_in.valid <= 1'b0;
    wait_drain();

    // Again with every discreet step on and the amount at its widest value
    apply_settings(with_junk(css_pkg::CFG_DATA_W'(css_pkg::METHOD_DISCREET), 1),
                   with_junk(css_pkg::CFG_DATA_W'(css_pkg::KEY_GREEN), 1), 16'hFFFF,
                   with_junk(16'h003F, css_pkg::MASK_W));
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    pix_in.valid <= 1'b0;
    wait_drain();

    for (int unsigned phase = 0; phase < 12; phase++) begin
      method_v = ($urandom_range(0, 1) != 0) ? css_pkg::METHOD_DISCREET
                                             : css_pkg::METHOD_BASIC;
      key_v    = ($urandom_range(0, 1) != 0) ? css_pkg::KEY_GREEN : css_pkg::KEY_BLUE;
      mask_v   = css_pkg::MASK_W'($urandom_range(0, 63));
      case ($urandom_range(0, 3))
        0:       amount_v = 15'd0;
        1:       amount_v = 15'd20480;
        2:       amount_v = css_pkg::AMT_W'($urandom_range(0, 20480));
        default: amount_v = css_pkg::AMT_W'($urandom_range(0, 32767));
      endcase
      // Pin the first phases to the extremes; leave the rest random.
      case (phase)
        0: begin
          method_v = css_pkg::METHOD_BASIC;
          key_v    = css_pkg::KEY_BLUE;
          amount_v = 15'd0;
        end
        1: begin
          method_v = css_pkg::METHOD_BASIC;
          key_v    = css_pkg::KEY_GREEN;
          amount_v = 15'd20480;
        end
        2: begin
          method_v = css_pkg::METHOD_BASIC;
          key_v    = css_pkg::KEY_BLUE;
          amount_v = 15'h7FFF;
        end
        3: begin
          method_v = css_pkg::METHOD_DISCREET;
          mask_v   = 6'h3F;
          amount_v = css_pkg::AMOUNT_RST;
        end
        4: begin
          method_v = css_pkg::METHOD_DISCREET;
          mask_v   = 6'h00;
          amount_v = 15'd20480;
        end
        5: begin
          method_v = css_pkg::METHOD_DISCREET;
          mask_v   = 6'h3F;
          amount_v = 15'd0;
        end
        default: ;
      endcase
      apply_settings(with_junk(css_pkg::CFG_DATA_W'(method_v), 1),
                     with_junk(css_pkg::CFG_DATA_W'(key_v), 1),
                     with_junk(css_pkg::CFG_DATA_W'(amount_v), css_pkg::AMT_W),
                     with_junk(css_pkg::CFG_DATA_W'(mask_v), css_pkg::MASK_W));

      count = 50;
      if (phase == 7) begin
        // Stall the output for a long stretch while input keeps coming, so the
        // pipe fills and the block must push back on its input.
        hold_request = HOLD_CYCLES;
        count        = 80;
      end
      send_stream(count, phase == 7, phase == 9);
      pix_in.valid <= 1'b0;
      wait_drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[chroma_spill_suppressor] OK");
    end else begin
      $display("[chroma_spill_suppressor] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/css_pkg.sv
hdl/css_if.sv
hdl/css_cfg_regs.sv
hdl/css_shape.sv
hdl/css_blend.sv
hdl/chroma_spill_suppressor.sv
test/tb_top.sv
